// ===== src/cue_sequence_frame_decoder_unit_defines.svh =====
// Assertion macros for the cue sequence frame decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CUE_SEQUENCE_FRAME_DECODER_UNIT_DEFINES_SVH
`define CUE_SEQUENCE_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/csfd_pkg.sv =====
// Types and constants for the cue sequence frame decoder.
// No dependencies; compiled first.
package csfd_pkg;

    localparam int HEADER_LEN = 5;
    localparam int RECORD_LEN = 16;
    localparam int POS_W      = 21;
    localparam int FIFO_DEPTH = 3;
    localparam int PTR_W      = 2;

    localparam logic [POS_W-1:0] POS_MAX     = {POS_W{1'b1}};
    localparam logic [7:0]       VERSION_OK  = 8'd1;
    localparam logic [15:0]      MAX_CUES_RST = 16'd64;

    // Header byte offsets
    localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_COUNT_LO = POS_W'(3);
    localparam logic [POS_W-1:0] POS_COUNT_HI = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(HEADER_LEN);

    localparam logic [3:0] REC_LAST = 4'(RECORD_LEN - 1);

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_VERSION  = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_TOO_MANY     = 3'd4
    } status_t;

    typedef struct packed {
        logic        is_cue;
        logic [7:0]  effect;
        logic [31:0] duration_ms;
        logic [23:0] color_first;
        logic [23:0] color_second;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [7:0]  brightness;
        logic        frame_done;
        status_t     status;
        logic [15:0] cue_total;
    } result_t;

endpackage

// ===== src/csfd_byte_if.sv =====
// Byte input channel of the cue sequence frame decoder.
// Valid/ready handshake; no dependencies.
interface csfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_frame;

    modport source (output valid, data_byte, end_of_frame, input ready);
    modport sink   (input valid, data_byte, end_of_frame, output ready);
endinterface

// ===== src/csfd_cfg_if.sv =====
// Configuration write channel carrying the max_cues register value.
// Valid/ready handshake; no dependencies.
interface csfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== src/csfd_result_if.sv =====
// Result channel: one decoded cue or one frame status per word.
// Valid/ready handshake; no dependencies.
interface csfd_result_if;
    logic        valid;
    logic        ready;
    logic        is_cue;
    logic [7:0]  effect;
    logic [31:0] duration_ms;
    logic [23:0] color_first;
    logic [23:0] color_second;
    logic [7:0]  param_one;
    logic [7:0]  param_two;
    logic [7:0]  brightness;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] cue_total;

    modport source (output valid, is_cue, effect, duration_ms, color_first, color_second,
                    param_one, param_two, brightness, frame_done, status, cue_total,
                    input ready);
    modport sink   (input valid, is_cue, effect, duration_ms, color_first, color_second,
                    param_one, param_two, brightness, frame_done, status, cue_total,
                    output ready);
endinterface

// ===== src/cue_sequence_frame_decoder_unit.sv =====
// Cue sequence frame decoder: top level.
// Depends on csfd_pkg, the csfd_*_if interfaces and the defines header.
//
// Usage:
//   frame  - one byte word per handshake, end_of_frame on the last byte.
//            Header is 5 bytes, then 16-byte cue records.
//   cue    - result words: a decoded cue (is_cue) after each full record,
//            and a status word (frame_done) after the last byte. Cues go
//            out before the frame is validated; drop them on a bad status.
//   cfg    - write of max_cues, always ready; write only while idle.
// A result word is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while frame.ready is high. A last byte that
// also closes a record gives two words, which leave the result side in turn.
// Results sit in a three-word queue; frame.ready is high while at least two
// slots are free, so a stalled receiver backs up into the byte channel
// without losing words.
// Reset clears the byte position, header fields and queue, and sets
// max_cues to 64. The record bytes hold no reset value.
`include "cue_sequence_frame_decoder_unit_defines.svh"

module cue_sequence_frame_decoder_unit
(
    input  logic          clk,
    input  logic          rst_n,
    csfd_byte_if.sink     frame,
    csfd_cfg_if.sink      cfg,
    csfd_result_if.source cue
);
    import csfd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       version_reg, version_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      max_cues_reg;
    logic [7:0]       record_reg [RECORD_LEN-1];

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_one, wr_ptr_two;
    logic [PTR_W-1:0] rd_ptr_inc;
    logic [PTR_W-1:0] cnt_reg, cnt_next;

    logic             accept, pop;
    logic             pos_live, in_record, rec_write, cue_push, status_push;
    logic [3:0]       rec_idx;
    status_t          status;
    result_t          cue_word, status_word, head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign accept      = frame.valid && frame.ready;
    assign pop         = cue.valid && cue.ready;
    assign frame.ready = (cnt_reg <= PTR_W'(FIFO_DEPTH - 2));
    assign cfg.ready   = 1'b1;

    // Record byte index is (pos - header) mod 16
    assign pos_live    = (pos_reg != POS_MAX);
    assign in_record   = pos_live && (pos_reg >= POS_HEADER);
    assign rec_idx     = pos_reg[3:0] - 4'(HEADER_LEN);
    assign rec_write   = accept && in_record && (rec_idx != REC_LAST);
    assign cue_push    = accept && in_record && (rec_idx == REC_LAST);
    assign status_push = accept && frame.end_of_frame;

    always_comb
    begin
        version_next = version_reg;
        count_next   = count_reg;
        if (pos_reg == POS_VERSION)
        begin
            version_next = frame.data_byte;
        end
        if (pos_reg == POS_COUNT_LO)
        begin
            count_next = {count_reg[15:8], frame.data_byte};
        end
        if (pos_reg == POS_COUNT_HI)
        begin
            count_next = {frame.data_byte, count_reg[7:0]};
        end
        pos_next = pos_live ? pos_reg + POS_W'(1) : pos_reg;
    end

    // Length check: pos + 1 == 5 + 16 * count  <=>  pos == {count, 4}
    always_comb
    begin
        if (pos_reg < POS_COUNT_HI)
        begin
            status = ST_TOO_SHORT;
        end
        else if (version_next != VERSION_OK)
        begin
            status = ST_BAD_VERSION;
        end
        else if (pos_reg != {1'b0, count_next, 4'(HEADER_LEN - 1)})
        begin
            status = ST_LEN_MISMATCH;
        end
        else if (count_next > max_cues_reg)
        begin
            status = ST_TOO_MANY;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        cue_word              = '0;
        cue_word.is_cue       = 1'b1;
        cue_word.effect       = record_reg[0];
        cue_word.duration_ms  = {record_reg[4], record_reg[3], record_reg[2], record_reg[1]};
        cue_word.color_first  = {record_reg[5], record_reg[6], record_reg[7]};
        cue_word.color_second = {record_reg[8], record_reg[9], record_reg[10]};
        cue_word.param_one    = record_reg[11];
        cue_word.param_two    = record_reg[12];
        cue_word.brightness   = record_reg[13];

        status_word            = '0;
        status_word.frame_done = 1'b1;
        status_word.status     = status;
        status_word.cue_total  = (status == ST_OK) ? count_next : 16'd0;
    end

    assign wr_ptr_one = ptr_inc(wr_ptr_reg);
    assign wr_ptr_two = ptr_inc(wr_ptr_one);
    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);
    assign cnt_next   = cnt_reg + PTR_W'(cue_push) + PTR_W'(status_push) - PTR_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            version_reg  <= '0;
            count_reg    <= '0;
            max_cues_reg <= MAX_CUES_RST;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                max_cues_reg <= cfg.data;
            end
            if (accept)
            begin
                // Last byte closes the frame: clear header state for the next one
                if (frame.end_of_frame)
                begin
                    pos_reg     <= '0;
                    version_reg <= '0;
                    count_reg   <= '0;
                end
                else if (pos_live)
                begin
                    pos_reg     <= pos_next;
                    version_reg <= version_next;
                    count_reg   <= count_next;
                end
            end
            if (cue_push && status_push)
            begin
                wr_ptr_reg <= wr_ptr_two;
            end
            else if (cue_push || status_push)
            begin
                wr_ptr_reg <= wr_ptr_one;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_inc;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_write)
        begin
            record_reg[rec_idx] <= frame.data_byte;
        end
        if (cue_push)
        begin
            fifo_reg[wr_ptr_reg] <= cue_word;
        end
        if (status_push)
        begin
            fifo_reg[cue_push ? wr_ptr_one : wr_ptr_reg] <= status_word;
        end
    end

    assign head             = fifo_reg[rd_ptr_reg];
    assign cue.valid        = (cnt_reg != '0);
    assign cue.is_cue       = head.is_cue;
    assign cue.effect       = head.effect;
    assign cue.duration_ms  = head.duration_ms;
    assign cue.color_first  = head.color_first;
    assign cue.color_second = head.color_second;
    assign cue.param_one    = head.param_one;
    assign cue.param_two    = head.param_two;
    assign cue.brightness   = head.brightness;
    assign cue.frame_done   = head.frame_done;
    assign cue.status       = head.status;
    assign cue.cue_total    = head.cue_total;

    `CSFD_ASSERT_NEXT(a_eof_clears_pos, accept && frame.end_of_frame, pos_reg == '0,
        "byte position not cleared after last byte")
    `CSFD_ASSERT_NEXT(a_pos_saturates, accept && !frame.end_of_frame && !pos_live,
        pos_reg == POS_MAX, "byte position left saturation")
    `CSFD_ASSERT_NOW(a_total_only_ok, cue.valid && cue.frame_done && cue.status != ST_OK,
        cue.cue_total == 16'd0, "cue_total set on a failing status")
    `CSFD_ASSERT_NOW(a_cue_not_done, cue.valid && cue.is_cue, !cue.frame_done,
        "cue word also marked as frame status")

endmodule
